// File: design/irpde_pkg.sv
// Package: shared types and constants for the pulse-distance IR encoder.
`default_nettype none

package irpde_pkg;

    localparam int DUR_W = 16;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARK  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_END_SPACE = 3'd6;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             is_mark;
        logic             run_last;
        logic             frame_end;
    } t_out_item;

    typedef struct packed {
        logic [DUR_W-1:0] header_mark_time;
        logic [DUR_W-1:0] header_space_time;
        logic [DUR_W-1:0] bit_mark_time;
        logic [DUR_W-1:0] one_space_time;
        logic [DUR_W-1:0] zero_space_time;
        logic [DUR_W-1:0] end_mark_time;
        logic [DUR_W-1:0] end_space_time;
    } t_cfg;

    typedef enum logic [2:0] {
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_END_MARK,
        PH_END_SPACE
    } t_phase;

    // Classified job handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        t_phase     start_phase;
        logic       has_end;
    } t_job;

    // Queue status seen by the back end
    typedef struct packed {
        logic not_empty;
        t_job head;
    } t_q_status;

endpackage

`default_nettype wire

// File: design/irpde_front.sv
// Front end: accepts input bytes, classifies them into jobs and queues them.
`default_nettype none

module irpde_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  irpde_pkg::t_in_item   i_in_item,
    input  wire                   i_pop,
    output irpde_pkg::t_q_status  o_status
);

    irpde_pkg::t_job r_mem [2];
    logic            r_wptr, n_wptr;
    logic            r_rptr, n_rptr;
    logic [1:0]      r_count, n_count;
    irpde_pkg::t_job w_job;
    logic            w_push;
    logic            w_pop;

    // Classify: where the sequence starts and whether an end pair follows
    always_comb begin
        w_job.data_byte   = i_in_item.data_byte;
        w_job.start_phase = i_in_item.first_byte ? irpde_pkg::PH_HDR_MARK
                                                 : irpde_pkg::PH_BIT_MARK;
        w_job.has_end     = i_in_item.last_byte;
    end

    assign o_in_stall = (r_count == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_count != 2'd0);

    always_comb begin
        n_wptr  = w_push ? ~r_wptr : r_wptr;
        n_rptr  = w_pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_job;
        end
    end

    assign o_status.not_empty = (r_count != 2'd0);
    assign o_status.head      = r_mem[r_rptr];

endmodule

`default_nettype wire

// File: design/irpde_back.sv
// Back end: steps through the mark/space sequence of each job, one per cycle unless the output stalls.
`default_nettype none

module irpde_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  irpde_pkg::t_cfg       i_cfg,
    input  irpde_pkg::t_q_status  i_status,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output irpde_pkg::t_out_item  o_out_item
);

    logic                 r_busy, n_busy;
    irpde_pkg::t_phase    r_phase, n_phase;
    logic [2:0]           r_bit, n_bit;
    logic [7:0]           r_data, n_data;
    logic                 r_has_end, n_has_end;
    logic                 r_out_valid, n_out_valid;
    irpde_pkg::t_out_item r_out_item;
    irpde_pkg::t_out_item w_res;
    logic                 w_adv;
    logic                 w_load;

    assign w_adv = r_busy && (!r_out_valid || !i_out_stall);

    // Next state
    always_comb begin
        n_busy    = r_busy;
        n_phase   = r_phase;
        n_bit     = r_bit;
        n_data    = r_data;
        n_has_end = r_has_end;
        w_load    = 1'b0;
        if (w_adv) begin
            case (r_phase)
                irpde_pkg::PH_HDR_MARK:  n_phase = irpde_pkg::PH_HDR_SPACE;
                irpde_pkg::PH_HDR_SPACE: begin
                    n_phase = irpde_pkg::PH_BIT_MARK;
                    n_bit   = 3'd0;
                end
                irpde_pkg::PH_BIT_MARK:  n_phase = irpde_pkg::PH_BIT_SPACE;
                irpde_pkg::PH_BIT_SPACE: begin
                    if (r_bit != irpde_pkg::LAST_BIT) begin
                        n_phase = irpde_pkg::PH_BIT_MARK;
                        n_bit   = r_bit + 3'd1;
                    end else if (r_has_end) begin
                        n_phase = irpde_pkg::PH_END_MARK;
                    end else begin
                        n_busy = 1'b0;
                    end
                end
                irpde_pkg::PH_END_MARK:  n_phase = irpde_pkg::PH_END_SPACE;
                irpde_pkg::PH_END_SPACE: n_busy = 1'b0;
                default:                 n_busy = 1'b0;
            endcase
        end
        // Take the next job when idle or as the current one finishes
        if ((!r_busy || (w_adv && w_res.run_last)) && i_status.not_empty) begin
            w_load    = 1'b1;
            n_busy    = 1'b1;
            n_phase   = i_status.head.start_phase;
            n_bit     = 3'd0;
            n_data    = i_status.head.data_byte;
            n_has_end = i_status.head.has_end;
        end
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    // Outputs of the current phase
    always_comb begin
        w_res = '0;
        case (r_phase)
            irpde_pkg::PH_HDR_MARK: begin
                w_res.duration = i_cfg.header_mark_time;
                w_res.is_mark  = 1'b1;
            end
            irpde_pkg::PH_HDR_SPACE: begin
                w_res.duration = i_cfg.header_space_time;
            end
            irpde_pkg::PH_BIT_MARK: begin
                w_res.duration = i_cfg.bit_mark_time;
                w_res.is_mark  = 1'b1;
            end
            irpde_pkg::PH_BIT_SPACE: begin
                w_res.duration = r_data[r_bit] ? i_cfg.one_space_time
                                               : i_cfg.zero_space_time;
                w_res.run_last = (r_bit == irpde_pkg::LAST_BIT) && !r_has_end;
            end
            irpde_pkg::PH_END_MARK: begin
                w_res.duration = i_cfg.end_mark_time;
                w_res.is_mark  = 1'b1;
            end
            irpde_pkg::PH_END_SPACE: begin
                w_res.duration  = i_cfg.end_space_time;
                w_res.run_last  = 1'b1;
                w_res.frame_end = 1'b1;
            end
            default: w_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= irpde_pkg::PH_BIT_MARK;
            r_bit       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data    <= n_data;
        r_has_end <= n_has_end;
        if (w_adv) begin
            r_out_item <= w_res;
        end
    end

    assign o_pop       = w_load;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// File: design/ir_pulse_distance_encoder_unit.sv
// Top level of the pulse-distance IR encoder: config registers, front and back ends.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) transfers one packet byte
//   with first/last flags. Output channel (o_out_valid / i_out_stall / o_out_item)
//   transfers one mark or space duration per transfer, strictly alternating.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) writes
//   the seven duration registers; ready is always high, unknown indexes are dropped.
//   Write config only while the encoder is idle.
// Timing:
//   A byte yields 16 durations, plus 2 with a header, plus 2 with an end pair.
//   The back-end sequencer emits one duration per cycle while the output is not
//   stalled; consecutive queued bytes follow with no gap.
//   From idle, a byte passes the job queue, sequencer state and output register.
//   A two-entry job queue decouples input acceptance from output stalls.
// Reset: synchronous, active low; queue empties, sequencer idles, all durations 0.
// Output stall: the output register holds its item and the sequencer pauses;
//   input is still taken until the queue is full.
`default_nettype none

module ir_pulse_distance_encoder_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  irpde_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output irpde_pkg::t_out_item                o_out_item,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [irpde_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [irpde_pkg::DUR_W-1:0]         i_cfg_data
);

    irpde_pkg::t_cfg      r_cfg;
    irpde_pkg::t_q_status w_status;
    logic                 w_pop;

    assign o_cfg_ready = 1'b1;

    // Duration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                irpde_pkg::REG_HDR_MARK:   r_cfg.header_mark_time  <= i_cfg_data;
                irpde_pkg::REG_HDR_SPACE:  r_cfg.header_space_time <= i_cfg_data;
                irpde_pkg::REG_BIT_MARK:   r_cfg.bit_mark_time     <= i_cfg_data;
                irpde_pkg::REG_ONE_SPACE:  r_cfg.one_space_time    <= i_cfg_data;
                irpde_pkg::REG_ZERO_SPACE: r_cfg.zero_space_time   <= i_cfg_data;
                irpde_pkg::REG_END_MARK:   r_cfg.end_mark_time     <= i_cfg_data;
                irpde_pkg::REG_END_SPACE:  r_cfg.end_space_time    <= i_cfg_data;
                default: ;  // out of range: ignored
            endcase
        end
    end

    irpde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_pop      (w_pop),
        .o_status   (w_status)
    );

    irpde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_status    (w_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
